[rtl/bft_pkg.sv]
// Shared types and constants of the bidirectional flow table.
package bft_pkg;

  localparam logic [7:0] PROTO_TCP = 8'd6;
  localparam logic [7:0] PROTO_UDP = 8'd17;

  localparam logic [2:0] STATUS_UNTRACKED = 3'd0;
  localparam logic [2:0] STATUS_NEW       = 3'd1;
  localparam logic [2:0] STATUS_FWD_HIT   = 3'd2;
  localparam logic [2:0] STATUS_REV_HIT   = 3'd3;
  localparam logic [2:0] STATUS_FULL      = 3'd4;

  localparam logic [6:0] STREAM_MAX = 7'd127;

  typedef struct packed {
    logic [7:0]  ip_protocol;
    logic [31:0] src_ip;
    logic [31:0] dst_ip;
    logic [15:0] src_port;
    logic [15:0] dst_port;
    logic [15:0] packet_length;
    logic [31:0] time_seconds;
    logic [19:0] time_microseconds;
  } in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [5:0]  flow_slot;
    logic [5:0]  stream_number;
    logic [31:0] packet_number;
    logic [31:0] flow_packets;
    logic [47:0] flow_bytes;
    logic [31:0] forward_packets;
    logic [47:0] forward_bytes;
    logic [31:0] reverse_packets;
    logic [47:0] reverse_bytes;
    logic [31:0] first_seconds;
    logic [19:0] first_microseconds;
  } out_t;

  typedef struct packed {
    logic [31:0] src_ip;
    logic [31:0] dst_ip;
    logic [15:0] src_port;
    logic [15:0] dst_port;
    logic        is_udp;
    logic [5:0]  stream;
    logic [31:0] packets;
    logic [47:0] bytes;
    logic [31:0] fwd_packets;
    logic [47:0] fwd_bytes;
    logic [31:0] rev_packets;
    logic [47:0] rev_bytes;
    logic [31:0] start_sec;
    logic [19:0] start_usec;
  } record_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE,
    ST_FETCH,
    ST_UPDATE
  } state_e;

endpackage

[rtl/bidirectional_flow_table_core.sv]
// Top level of the bidirectional five-tuple flow table.
//
//   channel | direction | handshake             | beat
//   --------+-----------+-----------------------+-----------------------------
//   in      | sink      | in_valid_i/in_stall_o | one packet header (in_t)
//   out     | source    | out_valid_o/out_stall_i | one flow result (out_t)
//
// One packet at a time. An untracked protocol skips the scan. A tracked
// packet scans the N slots in use through the single read port of the flow
// memory, one slot per cycle, before it reports a new flow or a full table;
// a hit then goes on to read, modify and write back the matching record.
// Slots fill in order and are never freed, so a fill count stands in for the
// valid bits; reset clears only control state and takes no clearing pass.
// A stalled result waits in the output register; the next packet is taken
// meanwhile and finishing it waits until the output register frees up.
module bidirectional_flow_table_core #(
  parameter int FLOW_SLOTS = 64
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  bft_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output bft_pkg::out_t out_data_o
);

  localparam int SlotW = (FLOW_SLOTS > 1) ? $clog2(FLOW_SLOTS) : 1;
  localparam int CntW  = $clog2(FLOW_SLOTS + 1);
  localparam logic [CntW-1:0] SlotsFull = CntW'(FLOW_SLOTS);

  // Flow record memory: one write port, one registered read port.
  bft_pkg::record_t mem_q [FLOW_SLOTS];
  bft_pkg::record_t rd_data_q;
  bft_pkg::record_t wr_data;
  logic             rd_en, wr_en;
  logic [SlotW-1:0] rd_addr, wr_addr;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_q <= mem_q[rd_addr];
    end
  end

  bft_pkg::state_e  state_q, state_d;
  bft_pkg::in_t     in_q;
  logic             track_q, track_d;
  logic [CntW-1:0]  scan_idx_q, scan_idx_d;
  logic [CntW-1:0]  used_q, used_d;
  logic             cmp_vld_q, cmp_vld_d;
  logic [SlotW-1:0] cmp_idx_q, cmp_idx_d;
  logic             fwd_found_q, fwd_found_d, rev_found_q, rev_found_d;
  logic [SlotW-1:0] fwd_idx_q, fwd_idx_d, rev_idx_q, rev_idx_d;
  logic [SlotW-1:0] slot_q, slot_d;
  logic             rev_sel_q, rev_sel_d;
  logic [6:0]       tcp_cnt_q, tcp_cnt_d, udp_cnt_q, udp_cnt_d;
  logic [31:0]      total_q, total_d;
  logic             out_valid_q, out_valid_d;
  bft_pkg::out_t    out_q, out_d;

  logic             accept, out_free, in_udp;
  logic             fwd_match, rev_match;
  logic [32:0]      total_inc;
  logic [32:0]      pk_sum, dir_pk_sum;
  logic [48:0]      by_sum, dir_by_sum;
  logic [31:0]      dir_pk;
  logic [47:0]      dir_by;
  bft_pkg::record_t upd_rec, new_rec;
  logic [SlotW+5:0] slot_wide_upd, slot_wide_new;
  logic [6:0]       stream_cnt;

  assign in_stall_o  = (state_q != bft_pkg::ST_IDLE);
  assign accept      = in_valid_i && !in_stall_o;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign in_udp      = (in_q.ip_protocol == bft_pkg::PROTO_UDP);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign total_inc   = {1'b0, total_q} + 33'd1;

  // Compare the slot just read in both orientations.
  assign fwd_match = (rd_data_q.is_udp == in_udp)
                  && (rd_data_q.src_ip == in_q.src_ip)
                  && (rd_data_q.dst_ip == in_q.dst_ip)
                  && (rd_data_q.src_port == in_q.src_port)
                  && (rd_data_q.dst_port == in_q.dst_port);
  assign rev_match = (rd_data_q.is_udp == in_udp)
                  && (rd_data_q.src_ip == in_q.dst_ip)
                  && (rd_data_q.dst_ip == in_q.src_ip)
                  && (rd_data_q.src_port == in_q.dst_port)
                  && (rd_data_q.dst_port == in_q.src_port);

  // Saturating update of the fetched record.
  assign pk_sum = {1'b0, rd_data_q.packets} + 33'd1;
  assign by_sum = {1'b0, rd_data_q.bytes} + {33'd0, in_q.packet_length};
  assign dir_pk = rev_sel_q ? rd_data_q.rev_packets : rd_data_q.fwd_packets;
  assign dir_by = rev_sel_q ? rd_data_q.rev_bytes : rd_data_q.fwd_bytes;
  assign dir_pk_sum = {1'b0, dir_pk} + 33'd1;
  assign dir_by_sum = {1'b0, dir_by} + {33'd0, in_q.packet_length};

  always_comb begin
    upd_rec         = rd_data_q;
    upd_rec.packets = pk_sum[32] ? '1 : pk_sum[31:0];
    upd_rec.bytes   = by_sum[48] ? '1 : by_sum[47:0];
    if (rev_sel_q) begin
      upd_rec.rev_packets = dir_pk_sum[32] ? '1 : dir_pk_sum[31:0];
      upd_rec.rev_bytes   = dir_by_sum[48] ? '1 : dir_by_sum[47:0];
    end else begin
      upd_rec.fwd_packets = dir_pk_sum[32] ? '1 : dir_pk_sum[31:0];
      upd_rec.fwd_bytes   = dir_by_sum[48] ? '1 : dir_by_sum[47:0];
    end
  end

  assign stream_cnt = in_udp ? udp_cnt_q : tcp_cnt_q;

  always_comb begin
    new_rec.src_ip      = in_q.src_ip;
    new_rec.dst_ip      = in_q.dst_ip;
    new_rec.src_port    = in_q.src_port;
    new_rec.dst_port    = in_q.dst_port;
    new_rec.is_udp      = in_udp;
    new_rec.stream      = stream_cnt[5:0];
    new_rec.packets     = 32'd1;
    new_rec.bytes       = {32'd0, in_q.packet_length};
    new_rec.fwd_packets = 32'd1;
    new_rec.fwd_bytes   = {32'd0, in_q.packet_length};
    new_rec.rev_packets = '0;
    new_rec.rev_bytes   = '0;
    new_rec.start_sec   = in_q.time_seconds;
    new_rec.start_usec  = in_q.time_microseconds;
  end

  // Report the low six bits of the slot index at any table size.
  assign slot_wide_upd = {6'd0, slot_q};
  assign slot_wide_new = {6'd0, used_q[SlotW-1:0]};

  always_comb begin
    state_d     = state_q;
    track_d     = track_q;
    scan_idx_d  = scan_idx_q;
    used_d      = used_q;
    cmp_vld_d   = 1'b0;
    cmp_idx_d   = cmp_idx_q;
    fwd_found_d = fwd_found_q;
    fwd_idx_d   = fwd_idx_q;
    rev_found_d = rev_found_q;
    rev_idx_d   = rev_idx_q;
    slot_d      = slot_q;
    rev_sel_d   = rev_sel_q;
    tcp_cnt_d   = tcp_cnt_q;
    udp_cnt_d   = udp_cnt_q;
    total_d     = total_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;
    rd_en       = 1'b0;
    rd_addr     = scan_idx_q[SlotW-1:0];
    wr_en       = 1'b0;
    wr_addr     = slot_q;
    wr_data     = upd_rec;

    unique case (state_q)
      bft_pkg::ST_IDLE: begin
        if (accept) begin
          total_d     = total_inc[32] ? '1 : total_inc[31:0];
          track_d     = (in_data_i.ip_protocol == bft_pkg::PROTO_TCP)
                     || (in_data_i.ip_protocol == bft_pkg::PROTO_UDP);
          scan_idx_d  = '0;
          fwd_found_d = 1'b0;
          rev_found_d = 1'b0;
          state_d     = track_d ? bft_pkg::ST_SCAN : bft_pkg::ST_DONE;
        end
      end

      bft_pkg::ST_SCAN: begin
        // Issue one slot read a cycle; compare the previous read.
        if (scan_idx_q != used_q) begin
          rd_en      = 1'b1;
          cmp_vld_d  = 1'b1;
          cmp_idx_d  = scan_idx_q[SlotW-1:0];
          scan_idx_d = scan_idx_q + CntW'(1);
        end else if (!cmp_vld_q) begin
          state_d = bft_pkg::ST_DONE;
        end
        if (cmp_vld_q) begin
          if (fwd_match && !fwd_found_q) begin
            fwd_found_d = 1'b1;
            fwd_idx_d   = cmp_idx_q;
          end
          if (rev_match && !rev_found_q) begin
            rev_found_d = 1'b1;
            rev_idx_d   = cmp_idx_q;
          end
        end
      end

      bft_pkg::ST_DONE: begin
        if (track_q && (fwd_found_q || rev_found_q)) begin
          slot_d    = fwd_found_q ? fwd_idx_q : rev_idx_q;
          rev_sel_d = !fwd_found_q;
          state_d   = bft_pkg::ST_FETCH;
        end else if (out_free) begin
          out_valid_d         = 1'b1;
          out_d               = '0;
          out_d.packet_number = total_q;
          state_d             = bft_pkg::ST_IDLE;
          if (!track_q) begin
            out_d.status = bft_pkg::STATUS_UNTRACKED;
          end else if (used_q == SlotsFull) begin
            out_d.status = bft_pkg::STATUS_FULL;
          end else begin
            // Insert into the lowest free slot.
            wr_en                    = 1'b1;
            wr_addr                  = used_q[SlotW-1:0];
            wr_data                  = new_rec;
            used_d                   = used_q + CntW'(1);
            out_d.status             = bft_pkg::STATUS_NEW;
            out_d.flow_slot          = slot_wide_new[5:0];
            out_d.stream_number      = new_rec.stream;
            out_d.flow_packets       = new_rec.packets;
            out_d.flow_bytes         = new_rec.bytes;
            out_d.forward_packets    = new_rec.fwd_packets;
            out_d.forward_bytes      = new_rec.fwd_bytes;
            out_d.first_seconds      = new_rec.start_sec;
            out_d.first_microseconds = new_rec.start_usec;
            if (in_udp) begin
              if (udp_cnt_q != bft_pkg::STREAM_MAX) udp_cnt_d = udp_cnt_q + 7'd1;
            end else begin
              if (tcp_cnt_q != bft_pkg::STREAM_MAX) tcp_cnt_d = tcp_cnt_q + 7'd1;
            end
          end
        end
      end

      bft_pkg::ST_FETCH: begin
        rd_en   = 1'b1;
        rd_addr = slot_q;
        state_d = bft_pkg::ST_UPDATE;
      end

      bft_pkg::ST_UPDATE: begin
        // Write back the updated record; hold until the output frees up.
        if (out_free) begin
          wr_en                    = 1'b1;
          out_valid_d              = 1'b1;
          out_d.status             = rev_sel_q ? bft_pkg::STATUS_REV_HIT
                                               : bft_pkg::STATUS_FWD_HIT;
          out_d.flow_slot          = slot_wide_upd[5:0];
          out_d.stream_number      = upd_rec.stream;
          out_d.packet_number      = total_q;
          out_d.flow_packets       = upd_rec.packets;
          out_d.flow_bytes         = upd_rec.bytes;
          out_d.forward_packets    = upd_rec.fwd_packets;
          out_d.forward_bytes      = upd_rec.fwd_bytes;
          out_d.reverse_packets    = upd_rec.rev_packets;
          out_d.reverse_bytes      = upd_rec.rev_bytes;
          out_d.first_seconds      = upd_rec.start_sec;
          out_d.first_microseconds = upd_rec.start_usec;
          state_d                  = bft_pkg::ST_IDLE;
        end
      end

      default: state_d = bft_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= bft_pkg::ST_IDLE;
      track_q     <= 1'b0;
      scan_idx_q  <= '0;
      used_q      <= '0;
      cmp_vld_q   <= 1'b0;
      fwd_found_q <= 1'b0;
      rev_found_q <= 1'b0;
      rev_sel_q   <= 1'b0;
      tcp_cnt_q   <= '0;
      udp_cnt_q   <= '0;
      total_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      track_q     <= track_d;
      scan_idx_q  <= scan_idx_d;
      used_q      <= used_d;
      cmp_vld_q   <= cmp_vld_d;
      fwd_found_q <= fwd_found_d;
      rev_found_q <= rev_found_d;
      rev_sel_q   <= rev_sel_d;
      tcp_cnt_q   <= tcp_cnt_d;
      udp_cnt_q   <= udp_cnt_d;
      total_q     <= total_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_q <= in_data_i;
    end
    cmp_idx_q <= cmp_idx_d;
    fwd_idx_q <= fwd_idx_d;
    rev_idx_q <= rev_idx_d;
    slot_q    <= slot_d;
    out_q     <= out_d;
  end

endmodule
